### rtl/hcpt_pkg.sv
// Shared constants, payload types and controller/datapath handshake types for the point tracker.
`timescale 1ns / 1ps

package hcpt_pkg;

  localparam int MAX_POINTS   = 16;
  localparam int COORD_BITS   = 12;
  localparam int RADIUS_BITS  = 12;
  localparam int HIT_W        = 3;
  localparam int IDX_W        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int SQ_W         = 2 * COORD_BITS;
  localparam int DIST_W       = 2 * COORD_BITS + 1;
  localparam int RSQ_W        = 2 * RADIUS_BITS;
  localparam int CMP_W        = (DIST_W > RSQ_W) ? DIST_W : RSQ_W;

  localparam logic [HIT_W-1:0]       HIT_LIMIT    = HIT_W'(6);
  localparam logic [HIT_W-1:0]       HIT_FIRST    = HIT_W'(1);
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(100);
  localparam logic [RSQ_W-1:0]       RSQ_RESET    = RSQ_W'(RADIUS_RESET) * RSQ_W'(RADIUS_RESET);

  typedef enum logic {
    CMD_OBSERVE = 1'b0,
    CMD_TICK    = 1'b1
  } item_cmd_t;

  typedef struct packed {
    item_cmd_t             cmd;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] best_x;
    logic [COORD_BITS-1:0] best_y;
    logic                  best_found;
    logic [CNT_W-1:0]      occupancy;
    logic                  dropped;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic compact;
    logic best;
    logic load_out;
  } hcpt_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic walk_done;
    logic out_busy;
  } hcpt_stat_t;

endpackage

### rtl/hcpt_dp.sv
// Datapath: entry table, distance pipeline, compaction and best-entry search.
`timescale 1ns / 1ps

module hcpt_dp import hcpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hcpt_cmd_t              cmd,
  output hcpt_stat_t             stat,
  input  in_item_t               in_data,
  input  logic                   cfg_we,
  input  logic [RADIUS_BITS-1:0] cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  logic [COORD_BITS-1:0] col_r  [MAX_POINTS];
  logic [COORD_BITS-1:0] row_r  [MAX_POINTS];
  logic [HIT_W-1:0]      hits_r [MAX_POINTS];

  logic [CNT_W-1:0]      live_r;
  logic [CNT_W-1:0]      rd_r;
  logic [CNT_W-1:0]      wr_r;
  logic                  p_vld_r;
  logic [IDX_W-1:0]      p_idx_r;
  logic [HIT_W-1:0]      p_hits_r;
  logic [SQ_W-1:0]       sqx_r;
  logic [SQ_W-1:0]       sqy_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [RSQ_W-1:0]      rsq_r;
  logic [HIT_W-1:0]      best_hits_r;
  logic [COORD_BITS-1:0] bx_r;
  logic [COORD_BITS-1:0] by_r;
  logic                  dropped_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      live_idx;
  logic [COORD_BITS-1:0] rd_col;
  logic [COORD_BITS-1:0] rd_row;
  logic [HIT_W-1:0]      rd_hits;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [DIST_W-1:0]     dist_sq;
  logic                  walk_done;
  logic                  match;
  logic                  scan_done;
  logic                  full;
  logic                  keep;
  logic                  found;

  assign rd_idx    = rd_r[IDX_W-1:0];
  assign wr_idx    = wr_r[IDX_W-1:0];
  assign live_idx  = live_r[IDX_W-1:0];
  assign rd_col    = col_r[rd_idx];
  assign rd_row    = row_r[rd_idx];
  assign rd_hits   = hits_r[rd_idx];
  assign dx        = (px_r >= rd_col) ? (px_r - rd_col) : (rd_col - px_r);
  assign dy        = (py_r >= rd_row) ? (py_r - rd_row) : (rd_row - py_r);
  assign dist_sq   = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign walk_done = (rd_r >= live_r);
  assign match     = p_vld_r && (CMP_W'(dist_sq) <= CMP_W'(rsq_r));
  assign scan_done = !p_vld_r && walk_done;
  assign full      = (live_r == CNT_W'(MAX_POINTS));
  assign keep      = (rd_hits > HIT_FIRST);
  assign found     = (best_hits_r > HIT_FIRST);

  assign stat.scan_end  = match || scan_done;
  assign stat.walk_done = walk_done;
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      p_vld_r     <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rsq_r       <= RSQ_RESET;
      for (int i = 0; i < MAX_POINTS; i++) begin
        hits_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        rsq_r <= RSQ_W'(cfg_data) * RSQ_W'(cfg_data);
      end
      if (cmd.start) begin
        rd_r      <= '0;
        wr_r      <= '0;
        p_vld_r   <= 1'b0;
        dropped_r <= 1'b0;
      end
      if (cmd.scan) begin
        if (match) begin
          hits_r[p_idx_r] <= (p_hits_r < HIT_LIMIT) ? (p_hits_r + HIT_W'(1)) : p_hits_r;
          rd_r            <= '0;
          p_vld_r         <= 1'b0;
        end else if (scan_done) begin
          if (!full) begin
            hits_r[live_idx] <= HIT_FIRST;
            live_r           <= live_r + CNT_W'(1);
          end else begin
            dropped_r <= 1'b1;
          end
          rd_r <= '0;
        end else begin
          p_vld_r <= !walk_done;
          if (!walk_done) begin
            rd_r <= rd_r + CNT_W'(1);
          end
        end
      end
      if (cmd.compact) begin
        if (!walk_done) begin
          if (keep) begin
            hits_r[wr_idx] <= rd_hits - HIT_W'(1);
            wr_r           <= wr_r + CNT_W'(1);
          end
          rd_r <= rd_r + CNT_W'(1);
        end else begin
          for (int i = 0; i < MAX_POINTS; i++) begin
            if (CNT_W'(i) >= wr_r) begin
              hits_r[i] <= '0;
            end
          end
          live_r <= wr_r;
          rd_r   <= '0;
        end
      end
      if (cmd.best && !walk_done) begin
        rd_r <= rd_r + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r        <= in_data.point_x;
      py_r        <= in_data.point_y;
      best_hits_r <= '0;
      bx_r        <= '0;
      by_r        <= '0;
    end
    if (cmd.scan) begin
      if (match) begin
        col_r[p_idx_r] <= px_r;
        row_r[p_idx_r] <= py_r;
      end else if (scan_done) begin
        if (!full) begin
          col_r[live_idx] <= px_r;
          row_r[live_idx] <= py_r;
        end
      end else begin
        sqx_r    <= SQ_W'(dx) * SQ_W'(dx);
        sqy_r    <= SQ_W'(dy) * SQ_W'(dy);
        p_idx_r  <= rd_idx;
        p_hits_r <= rd_hits;
      end
    end
    if (cmd.compact && !walk_done && keep) begin
      col_r[wr_idx] <= rd_col;
      row_r[wr_idx] <= rd_row;
    end
    if (cmd.best && !walk_done && (rd_hits > best_hits_r)) begin
      best_hits_r <= rd_hits;
      bx_r        <= rd_col;
      by_r        <= rd_row;
    end
    if (cmd.load_out) begin
      out_r.best_x     <= found ? bx_r : '0;
      out_r.best_y     <= found ? by_r : '0;
      out_r.best_found <= found;
      out_r.occupancy  <= live_r;
      out_r.dropped    <= dropped_r;
    end
  end

`ifndef SYNTHESIS
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> (live_r == CNT_W'(MAX_POINTS)))
    else $error("drop flagged with free table space");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compact |-> (wr_r <= rd_r))
    else $error("compaction write overtook read");

  a_found_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.best_found) |-> (out_r.occupancy != '0))
    else $error("best entry reported from empty table");
`endif

endmodule

### rtl/hcpt_ctrl.sv
// Controller: sequences scan, compaction, best search and result hand-off.
`timescale 1ns / 1ps

module hcpt_ctrl import hcpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  item_cmd_t  in_cmd,
  output logic       in_stall,
  input  hcpt_stat_t stat,
  output hcpt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_BEST,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.start    = accept;
    cmd.scan     = (state_r == S_SCAN);
    cmd.compact  = (state_r == S_COMPACT);
    cmd.best     = (state_r == S_BEST);
    cmd.load_out = (state_r == S_EMIT) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (in_cmd == CMD_TICK) ? S_COMPACT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_end) begin
            state_r <= S_BEST;
          end
        end
        S_COMPACT: begin
          if (stat.walk_done) begin
            state_r <= S_BEST;
          end
        end
        S_BEST: begin
          if (stat.walk_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!stat.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/hit_count_point_tracker_top.sv
// With N live entries, an item walks them (distance pipeline or compaction, then best search)
// before its result is loaded, and it also waits while the previous result is still stalled.
// Throughput: one transaction in flight; the next is accepted once the result sits in the
// output register, even while that result is still stalled.
// Reset (synchronous, rst_n low) empties the table and loads a match radius of 100.
`timescale 1ns / 1ps

module hit_count_point_tracker_top import hcpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [RADIUS_BITS-1:0] cfg_data
);

  hcpt_cmd_t  cmd;
  hcpt_stat_t stat;

  assign cfg_ready = 1'b1;

  hcpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hcpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
